// ----- src/rss_pkg.sv -----
// Shared types for the running sample statistics block.
// No dependencies; compile this file first.
package rss_pkg;

	// Sequencer states of the statistics engine.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} rss_state_t;

	// Control strobes from the sequencer to the datapath.
	typedef struct packed {
		logic take;
		logic div_step;
		logic load_out;
	} rss_ctrl_t;

endpackage

// ----- src/running_sample_statistics.sv -----
// Running sample statistics: last, count, sum, mean, minimum and maximum of a sample stream.
// The radix-2 divider produces one quotient bit a cycle; a new word is taken only once it is done.
// The next input word is taken while the previous result still waits in the output register.
// Reset (arst_n, asynchronous, active low) clears all statistics to zero and empties the output.
// Depends on rss_pkg.
module running_sample_statistics #(
	parameter int SAMPLE_BITS = 40,
	parameter int COUNT_BITS  = 32,
	parameter int SUM_BITS    = 56
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] last_sample,
	output logic [COUNT_BITS-1:0]  sample_count,
	output logic [SUM_BITS-1:0]    sample_sum,
	output logic [SAMPLE_BITS-1:0] mean_value,
	output logic [SAMPLE_BITS-1:0] minimum_value,
	output logic [SAMPLE_BITS-1:0] maximum_value
);
	import rss_pkg::*;

	// The saturating add is done one bit wider than the larger operand, so that
	// neither the sum nor the sample loses bits whatever the parameters are.
	localparam int ADD_BITS = ((SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS) + 1;
	localparam int IDX_BITS = $clog2(SUM_BITS);
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SUM_BITS - 1);

	rss_state_t state_q, state_d;
	rss_ctrl_t  ctrl;

	// Running statistics.
	logic [SAMPLE_BITS-1:0] last_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [SAMPLE_BITS-1:0] low_q;
	logic [SAMPLE_BITS-1:0] high_q;

	// Divider: partial remainder, dividend/quotient shift register and bit counter.
	logic [COUNT_BITS-1:0]  rem_q;
	logic [SUM_BITS-1:0]    quo_q;
	logic [IDX_BITS-1:0]    idx_q;

	// Output register.
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] last_out_q;
	logic [COUNT_BITS-1:0]  count_out_q;
	logic [SUM_BITS-1:0]    sum_out_q;
	logic [SAMPLE_BITS-1:0] mean_out_q;
	logic [SAMPLE_BITS-1:0] low_out_q;
	logic [SAMPLE_BITS-1:0] high_out_q;

	logic                   first;
	logic [ADD_BITS-1:0]    add_full;
	logic [SUM_BITS-1:0]    sum_next;
	logic [COUNT_BITS-1:0]  count_next;
	logic [COUNT_BITS:0]    trial;
	logic                   fits;
	logic [SAMPLE_BITS-1:0] mean_clamped;

	// A sample taken while the count is zero seeds both minimum and maximum.
	// Once the count saturates it is never zero again, so this cannot retrigger.
	assign first = (count_q == '0);

	// Saturating count and sum updates.
	assign count_next = (count_q == '1) ? count_q : count_q + COUNT_BITS'(1);
	assign add_full   = ADD_BITS'(sum_q) + ADD_BITS'(sample_value);
	assign sum_next   = (add_full > ADD_BITS'({SUM_BITS{1'b1}})) ? '1 : add_full[SUM_BITS-1:0];

	// One restoring division step: shift in the next dividend bit and try the subtract.
	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign fits  = (trial >= {1'b0, count_q});

	// A quotient wider than the sample is clamped to the largest sample value.
	generate
		if (SUM_BITS > SAMPLE_BITS) begin : g_clamp
			assign mean_clamped = (quo_q[SUM_BITS-1:SAMPLE_BITS] != '0) ? '1
				: quo_q[SAMPLE_BITS-1:0];
		end else begin : g_extend
			assign mean_clamped = SAMPLE_BITS'(quo_q);
		end
	endgenerate

	// Sequencer: idle until a word arrives, run the divider, then hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (idx_q == '0) state_d = ST_DONE;
			end
			ST_DONE: begin
				// Wait only while an older result is still unclaimed.
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.take     = in_valid;
			ST_DIV:  ctrl.div_step = 1'b1;
			ST_DONE: ctrl.load_out = !out_valid_q || out_ready;
			default: ctrl = '0;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// Statistics state; reset to zero as part of the visible behavior.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
		end else if (ctrl.take) begin
			last_q  <= sample_value;
			count_q <= count_next;
			sum_q   <= sum_next;
			if (first || sample_value < low_q) low_q <= sample_value;
			if (first || sample_value > high_q) high_q <= sample_value;
		end
	end

	// Divider datapath. The divisor is the updated count, which is never zero here.
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			rem_q <= '0;
			quo_q <= sum_next;
			idx_q <= LAST_IDX;
		end else if (ctrl.div_step) begin
			rem_q <= fits ? COUNT_BITS'(trial - {1'b0, count_q}) : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
			idx_q <= idx_q - IDX_BITS'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			last_out_q  <= last_q;
			count_out_q <= count_q;
			sum_out_q   <= sum_q;
			mean_out_q  <= mean_clamped;
			low_out_q   <= low_q;
			high_out_q  <= high_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign last_sample   = last_out_q;
	assign sample_count  = count_out_q;
	assign sample_sum    = sum_out_q;
	assign mean_value    = mean_out_q;
	assign minimum_value = low_out_q;
	assign maximum_value = high_out_q;

endmodule

// ----- src/rss_checker.sv -----
// Port-level assertions for running_sample_statistics, attached with a bind.
// Depends on running_sample_statistics for the bind target.
module rss_checker #(
	parameter int SAMPLE_BITS = 40,
	parameter int COUNT_BITS  = 32,
	parameter int SUM_BITS    = 56
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [SAMPLE_BITS-1:0] sample_value,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] last_sample,
	input logic [COUNT_BITS-1:0]  sample_count,
	input logic [SUM_BITS-1:0]    sample_sum,
	input logic [SAMPLE_BITS-1:0] mean_value,
	input logic [SAMPLE_BITS-1:0] minimum_value,
	input logic [SAMPLE_BITS-1:0] maximum_value
);

	// A held result must not change while it waits.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_count) && $stable(mean_value))
		else $error("output word changed while stalled");

	// The engine works on one word at a time, so it is busy right after a take.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while the divider is running");

	// Every result follows at least one sample.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_count != '0)
		else $error("result with zero count");

	// Minimum never exceeds maximum.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> minimum_value <= maximum_value)
		else $error("minimum above maximum");

endmodule

bind running_sample_statistics rss_checker #(
	.SAMPLE_BITS(SAMPLE_BITS),
	.COUNT_BITS (COUNT_BITS),
	.SUM_BITS   (SUM_BITS)
) u_rss_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for running_sample_statistics: sample words in, statistics words out.
// Depends on src/running_sample_statistics.sv and src/rss_pkg.sv, compiled ahead of this file.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Widths match the block's default parameters. They are handed to the instance,
	// so the predictor follows if they are changed.
	localparam int SAMPLE_BITS = 40;
	localparam int COUNT_BITS  = 32;
	localparam int SUM_BITS    = 56;

	// One divide pass plus slack. Used when waiting for stray words at the end.
	localparam int PASS_CYCLES = SUM_BITS + 2;

	// Worst case per word is roughly a divide pass, the longest sender gap and a slow
	// drain on the output. The limit allows for about 1000 words at that worst case,
	// several times over.
	localparam int CYCLE_LIMIT = 1_500_000;

	localparam int MAX_REPORTS = 10;

	// One statistics word as the block presents it after each sample.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] last;
		logic [COUNT_BITS-1:0]  count;
		logic [SUM_BITS-1:0]    total;
		logic [SAMPLE_BITS-1:0] mean;
		logic [SAMPLE_BITS-1:0] low;
		logic [SAMPLE_BITS-1:0] high;
	} stats_word_t;

	// How the result side takes words.
	// PATTERN stalls on a rotating random mask. ALWAYS never stalls.
	// TRICKLE stalls for long stretches so that the output register backs up into the input.
	typedef enum logic [1:0] {
		DRAIN_PATTERN,
		DRAIN_ALWAYS,
		DRAIN_TRICKLE
	} drain_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] sample_value = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [SAMPLE_BITS-1:0] last_sample;
	logic [COUNT_BITS-1:0]  sample_count;
	logic [SUM_BITS-1:0]    sample_sum;
	logic [SAMPLE_BITS-1:0] mean_value;
	logic [SAMPLE_BITS-1:0] minimum_value;
	logic [SAMPLE_BITS-1:0] maximum_value;

	// The predictor's own copy of the running statistics. Like the block, it starts at zero.
	logic [SAMPLE_BITS-1:0] seen_last = '0;
	logic [COUNT_BITS-1:0]  seen_count = '0;
	logic [SUM_BITS-1:0]    seen_total = '0;
	logic [SAMPLE_BITS-1:0] seen_low = '0;
	logic [SAMPLE_BITS-1:0] seen_high = '0;

	// Statistics words predicted but not yet seen at the output, oldest first.
	stats_word_t pending_stats[$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// Sender burst state. A gap of idle cycles comes only between bursts.
	// A maximum gap of zero gives an unbroken stream.
	int unsigned burst_left = 0;
	int unsigned max_gap = 12;

	drain_mode_t   drain_mode = DRAIN_PATTERN;
	logic [15:0]   drain_mask = 16'hffff;
	logic [3:0]    drain_phase = '0;

	running_sample_statistics #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS),
		.SUM_BITS   (SUM_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.last_sample  (last_sample),
		.sample_count (sample_count),
		.sample_sum   (sample_sum),
		.mean_value   (mean_value),
		.minimum_value(minimum_value),
		.maximum_value(maximum_value)
	);

	always #4 clk = ~clk;

	// The run is bounded by a cycle counter. Reaching the limit means a word was lost
	// or the handshake hung.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d statistics words outstanding",
				cycle_count, pending_stats.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result-side ready. The mask is redrawn each time the phase counter wraps, so stalls
	// of varied length fall on every phase of the divider. Trickle mode raises ready only
	// when a draw from 0 to 99 comes up zero. On average that wait is longer than a divide
	// pass, so the held result blocks the next sample.
	always @(posedge clk) begin
		drain_phase <= drain_phase + 1'b1;
		if (drain_phase == 4'hf)
			drain_mask <= 16'($urandom);
		case (drain_mode)
			DRAIN_ALWAYS:  out_ready <= 1'b1;
			DRAIN_TRICKLE: out_ready <= ($urandom_range(0, 99) == 0);
			default:       out_ready <= drain_mask[drain_phase];
		endcase
	end

	// Advance the predicted statistics by one sample and return the word the block
	// must present. The sum saturates at all ones. A saturated count no longer counts
	// as a first sample. The mean is clamped to the sample range.
	function automatic stats_word_t predict_stats(input logic [SAMPLE_BITS-1:0] v);
		stats_word_t w;
		logic        first;
		logic [SUM_BITS:0]   wide_total;
		logic [SUM_BITS-1:0] quotient;

		first = (seen_count == '0);
		seen_last = v;
		if (seen_count != '1)
			seen_count = seen_count + 1'b1;
		wide_total = {1'b0, seen_total} + v;
		seen_total = wide_total[SUM_BITS] ? '1 : wide_total[SUM_BITS-1:0];
		quotient = seen_total / seen_count;
		if (first || v < seen_low)
			seen_low = v;
		if (first || v > seen_high)
			seen_high = v;

		w.last  = seen_last;
		w.count = seen_count;
		w.total = seen_total;
		w.mean  = ((quotient >> SAMPLE_BITS) != '0) ? '1 : quotient[SAMPLE_BITS-1:0];
		w.low   = seen_low;
		w.high  = seen_high;
		return w;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
					$realtime, name, want, got);
		end
	endtask

	// Result monitor. Outputs are read right after the edge, before the block's own
	// updates land, so these are the values that were handed over at this edge.
	always @(posedge clk) begin
		stats_word_t want;

		if (arst_n && out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: statistics word with none expected, count 0x%0h",
						$realtime, sample_count);
			end else begin
				want = pending_stats.pop_front();
				check_field("last_sample",   want.last,  last_sample);
				check_field("sample_count",  want.count, sample_count);
				check_field("sample_sum",    want.total, sample_sum);
				check_field("mean_value",    want.mean,  mean_value);
				check_field("minimum_value", want.low,   minimum_value);
				check_field("maximum_value", want.high,  maximum_value);
			end
		end
	end

	// Offer one sample word and hold it until it is taken. Between bursts the sender
	// goes idle and drives junk on the data lines. The expected statistics are queued
	// at the edge that accepts the word.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
		int unsigned gap;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			if (gap != 0) begin
				in_valid <= 1'b0;
				sample_value <= SAMPLE_BITS'({$urandom, $urandom});
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		pending_stats.push_back(predict_stats(v));
	endtask

	// A mix of extremes, single bits, small values, values near the current minimum
	// and maximum, and full-range random values.
	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		int unsigned bit_pos;

		bit_pos = $urandom_range(0, SAMPLE_BITS - 1);
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return '1;
			2:       return SAMPLE_BITS'(1) << bit_pos;
			3:       return ~(SAMPLE_BITS'(1) << bit_pos);
			4:       return SAMPLE_BITS'($urandom_range(0, 1000));
			5:       return seen_low - SAMPLE_BITS'($urandom_range(0, 3));
			6:       return seen_high + SAMPLE_BITS'($urandom_range(0, 3));
			7:       return SAMPLE_BITS'({$urandom, $urandom}) >> bit_pos;
			default: return SAMPLE_BITS'({$urandom, $urandom});
		endcase
	endfunction

	// The first sample after reset must set both the minimum and the maximum, even
	// though the held minimum of zero is smaller. The rest covers all-zero, all-one,
	// alternating and single-bit samples, and means that truncate.
	task automatic test_first_sample_and_extremes();
		send_sample('1);
		send_sample('0);
		send_sample(SAMPLE_BITS'(1));
		send_sample({(SAMPLE_BITS / 2){2'b01}});
		send_sample({(SAMPLE_BITS / 2){2'b10}});
		send_sample(SAMPLE_BITS'(1) << (SAMPLE_BITS - 1));
		send_sample(~(SAMPLE_BITS'(1) << (SAMPLE_BITS - 1)));
		send_sample('1);
		send_sample('1);
		send_sample('0);
	endtask

	// Small values keep the mean low, so a truncated remainder shows up clearly.
	task automatic test_mean_truncation();
		send_sample(SAMPLE_BITS'(2));
		send_sample(SAMPLE_BITS'(3));
		send_sample(SAMPLE_BITS'(7));
		send_sample(SAMPLE_BITS'(1));
		send_sample(SAMPLE_BITS'(5));
		send_sample(SAMPLE_BITS'(1000));
	endtask

	// A long stream with no sender gaps and no result stalls, which runs the block at
	// its full rate.
	task automatic test_steady_stream();
		drain_mode = DRAIN_ALWAYS;
		max_gap = 0;
		repeat (100) send_sample(random_sample());
		max_gap = 12;
	endtask

	// Results drain slowly, so the next sample has to wait behind a held result.
	task automatic test_output_backpressure();
		drain_mode = DRAIN_TRICKLE;
		max_gap = 0;
		repeat (30) send_sample(random_sample());
		max_gap = 12;
	endtask

	// The bulk of the run: bursty sender, patterned stalls on the result side.
	task automatic test_random_samples();
		drain_mode = DRAIN_PATTERN;
		repeat (850) send_sample(random_sample());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_sample_and_extremes();
		test_mean_truncation();
		test_random_samples();
		test_steady_stream();
		test_output_backpressure();

		// Let the remaining results drain, then watch a couple of divide passes more
		// in case a stray word shows up.
		in_valid <= 1'b0;
		drain_mode = DRAIN_ALWAYS;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (2 * PASS_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_stats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
